@@ rtl/bounded_sequential_list_engine_defines.svh @@
// assertion helpers for the list engine
`ifndef BOUNDED_SEQUENTIAL_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_SEQUENTIAL_LIST_ENGINE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define BSLE_ASSERT_SAME(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("bsle check failed");

// next-cycle implication, clocked on clk, off during reset
`define BSLE_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("bsle check failed");

`endif

@@ rtl/bsle_pkg.sv @@
package bsle_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int AW         = $clog2(DEPTH);
    localparam int CW         = $clog2(DEPTH + 1);

    localparam int POS_W = 7;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int CMP_W = (POS_W > CW) ? POS_W : CW;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_POP_BACK   = 3'd1,
        OP_PUSH_FRONT = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_INSERT     = 3'd4,
        OP_ERASE      = 3'd5,
        OP_FIND       = 3'd6
    } opcode_t;

    typedef struct packed {
        opcode_t            opcode;
        logic signed [31:0] value;
        logic [POS_W-1:0]   position;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             found;
        logic [IDX_W-1:0] found_index;
        logic [CNT_W-1:0] count;
    } out_beat_t;

    // result handoff from the sequencer to the output register
    typedef struct packed {
        logic      done;
        out_beat_t beat;
    } res_t;

endpackage

@@ rtl/bounded_sequential_list_engine.sv @@
// push back, pop back, every error case: straight to the done state, no store entries move
// insert, push front: shift n entries up, then write in S_PUT; erase, pop front: shift n down
// find: compares from index 0 upward, one per cycle through the registered store read port
// one beat at a time: in_stall holds until the sequencer leaves done and hands its result over
// reset clears the element count and control; store contents stay undefined, no clearing pass
`include "bounded_sequential_list_engine_defines.svh"

module bounded_sequential_list_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  bsle_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output bsle_pkg::out_beat_t out_data
);
    import bsle_pkg::*;

    logic      busy;
    logic      take;
    logic      res_free;
    res_t      res;
    logic      out_valid_reg, out_valid_next;
    out_beat_t out_data_reg;

    assign in_stall = busy;
    assign take     = in_valid && !busy;
    assign res_free = !out_valid_reg || !out_stall;

    bsle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .beat     (in_data),
        .res_free (res_free),
        .busy     (busy),
        .res      (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res.done && res_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.done && res_free)
        begin
            out_data_reg <= res.beat;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `BSLE_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
    `BSLE_ASSERT_SAME(a_found_ok, out_valid && out_data.found, out_data.status == ST_OK)
    `BSLE_ASSERT_SAME(a_count_bound, out_valid, out_data.count <= CNT_W'(DEPTH))

endmodule

@@ rtl/bsle_ram.sv @@
module bsle_ram #(
    parameter int WIDTH = 32,
    parameter int ENTRIES = 64,
    parameter int ADDR_W = $clog2(ENTRIES)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/bsle_ctrl.sv @@
module bsle_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  bsle_pkg::in_beat_t beat,
    input  logic              res_free,
    output logic              busy,
    output bsle_pkg::res_t    res
);
    import bsle_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_UP   = 6'b000010,
        S_DN   = 6'b000100,
        S_FIND = 6'b001000,
        S_PUT  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    logic [AW-1:0]         cursor_reg, cursor_next;
    logic [AW-1:0]         last_reg, last_next;
    logic                  issue_reg, issue_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         pend_addr_reg, pend_addr_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [1:0]            status_reg, status_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      fidx_reg, fidx_next;

    logic                  we;
    logic [AW-1:0]         waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [AW-1:0]         raddr;
    logic [DATA_WIDTH-1:0] rdata;

    bsle_ram #(
        .WIDTH   (DATA_WIDTH),
        .ENTRIES (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        logic [CMP_W-1:0]      pos_c;
        logic [CMP_W-1:0]      cnt_c;
        logic                  full;
        logic                  empty;
        logic [AW-1:0]         cnt_a;
        logic [AW-1:0]         cnt_m1;
        logic [DATA_WIDTH-1:0] v;
        logic                  go_up;
        logic                  go_dn;
        logic [AW-1:0]         lo;

        state_next     = state_reg;
        cursor_next    = cursor_reg;
        last_next      = last_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        val_next       = val_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        fidx_next      = fidx_reg;

        we    = 1'b0;
        waddr = pend_addr_reg;
        wdata = rdata;
        raddr = cursor_reg;

        pos_c  = CMP_W'(beat.position);
        cnt_c  = CMP_W'(count_reg);
        full   = (count_reg == CW'(DEPTH));
        empty  = (count_reg == '0);
        cnt_a  = count_reg[AW-1:0];
        cnt_m1 = cnt_a - 1'b1;
        v      = DATA_WIDTH'($unsigned(beat.value));
        go_up  = 1'b0;
        go_dn  = 1'b0;
        lo     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    val_next    = v;
                    status_next = ST_OK;
                    found_next  = 1'b0;
                    fidx_next   = '0;
                    pend_next   = 1'b0;
                    state_next  = S_DONE;
                    case (beat.opcode)
                        OP_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                waddr      = cnt_a;
                                wdata      = v;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                go_up = 1'b1;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                go_dn = 1'b1;
                            end
                        end
                        OP_INSERT:
                        begin
                            if (pos_c > cnt_c)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                go_up = 1'b1;
                                lo    = beat.position[AW-1:0];
                            end
                        end
                        OP_ERASE:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (pos_c >= cnt_c)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                go_dn = 1'b1;
                                lo    = beat.position[AW-1:0];
                            end
                        end
                        OP_FIND:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                cursor_next = '0;
                                last_next   = cnt_m1;
                                issue_next  = 1'b1;
                                state_next  = S_FIND;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase

                    pos_next = lo;
                    // open a gap: entries [lo, count) move up one place
                    if (go_up)
                    begin
                        if (lo == cnt_a)
                        begin
                            we         = 1'b1;
                            waddr      = lo;
                            wdata      = v;
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            cursor_next = cnt_m1;
                            last_next   = lo;
                            issue_next  = 1'b1;
                            state_next  = S_UP;
                        end
                    end
                    // close a gap: entries (lo, count) move down one place
                    if (go_dn)
                    begin
                        if (lo == cnt_m1)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                        else
                        begin
                            cursor_next = lo + 1'b1;
                            last_next   = cnt_m1;
                            issue_next  = 1'b1;
                            state_next  = S_DN;
                        end
                    end
                end
            end
            S_UP, S_DN, S_FIND:
            begin
                if (pend_reg && (state_reg != S_FIND))
                begin
                    we    = 1'b1;
                    waddr = (state_reg == S_UP) ? pend_addr_reg + 1'b1
                                                : pend_addr_reg - 1'b1;
                end
                if (issue_reg)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = cursor_reg;
                    if (cursor_reg == last_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else if (state_reg == S_UP)
                    begin
                        cursor_next = cursor_reg - 1'b1;
                    end
                    else
                    begin
                        cursor_next = cursor_reg + 1'b1;
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if ((state_reg == S_FIND) && pend_reg && (rdata == val_reg))
                begin
                    found_next = 1'b1;
                    fidx_next  = IDX_W'(pend_addr_reg);
                    issue_next = 1'b0;
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                end
                else if (!issue_reg)
                begin
                    if (state_reg == S_UP)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        if (state_reg == S_DN)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                        state_next = S_DONE;
                    end
                end
            end
            S_PUT:
            begin
                we         = 1'b1;
                waddr      = pos_reg;
                wdata      = val_reg;
                count_next = count_reg + 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            issue_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            issue_reg <= issue_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cursor_reg    <= cursor_next;
        last_reg      <= last_next;
        pend_addr_reg <= pend_addr_next;
        val_reg       <= val_next;
        pos_reg       <= pos_next;
        status_reg    <= status_next;
        found_reg     <= found_next;
        fidx_reg      <= fidx_next;
    end

    assign busy                 = (state_reg != S_IDLE);
    assign res.done             = (state_reg == S_DONE);
    assign res.beat.status      = status_reg;
    assign res.beat.found       = found_reg;
    assign res.beat.found_index = fidx_reg;
    assign res.beat.count       = CNT_W'(count_reg);

endmodule
